[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/phcc_pkg.sv]
package phcc_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_HDR   = 3'd1;
	localparam logic [2:0] ST_BAD_TYPE = 3'd2;
	localparam logic [2:0] ST_BAD_TR   = 3'd3;
	localparam logic [2:0] ST_BAD_LEN  = 3'd4;
	localparam logic [2:0] ST_CRC      = 3'd5;
	localparam logic [2:0] ST_INCONS   = 3'd6;
	localparam logic [2:0] ST_TRUNC    = 3'd7;

	localparam logic [1:0] TYPE_NONE = 2'd0;
	localparam logic [1:0] TYPE_DATA = 2'd1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	localparam logic [16:0] HDR_SHORT     = 17'd6;
	localparam logic [16:0] HDR_DATA      = 17'd8;
	localparam logic [16:0] PAYLOAD_START = 17'd12;
	localparam logic [16:0] POS_MAX       = 17'h1FFFF;
	localparam logic [7:0]  TR_CLEAR_MASK = 8'hDF;
	localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;

	typedef struct packed {
		logic        valid;
		logic        item_kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic [1:0]  type_code;
		logic        trunc_flag;
		logic [4:0]  window;
		logic [7:0]  seq_number;
		logic [15:0] payload_len;
		logic [31:0] timestamp;
	} phcc_result_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[sv/phcc_parser.sv]
module phcc_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic [15:0]           max_payload_len,
	output phcc_pkg::phcc_result_t result
);
	import phcc_pkg::*;

	logic [16:0] pos_q;
	logic [31:0] crc_q;
	logic [31:0] rcrc_q;
	logic [1:0]  type_q;
	logic        tr_q;
	logic [4:0]  win_q;
	logic [7:0]  seq_q;
	logic [15:0] len_q;
	logic [31:0] ts_q;
	logic [2:0]  err_q;

	logic [16:0] pos_n;
	logic [31:0] crc_n;
	logic [31:0] rcrc_n;
	logic [1:0]  type_n;
	logic        tr_n;
	logic [4:0]  win_n;
	logic [7:0]  seq_n;
	logic [15:0] len_n;
	logic [31:0] ts_n;
	logic [2:0]  err_n;
	logic        pass;
	logic [2:0]  status;

	logic [16:0] hlen;
	logic [16:0] pay_end;
	logic [16:0] crc_end;
	logic [31:0] rc_shift;
	logic [1:0]  ts_idx;
	logic        is_data;
	logic        has_len;

	assign pay_end  = {1'b0, len_q} + PAYLOAD_START;
	assign crc_end  = pay_end + 17'd4;
	assign rc_shift = {rcrc_q[23:0], data_byte};

	always_comb begin
		type_n = type_q;
		tr_n   = tr_q;
		win_n  = win_q;
		seq_n  = seq_q;
		len_n  = len_q;
		ts_n   = ts_q;
		err_n  = err_q;
		crc_n  = crc_q;
		rcrc_n = rcrc_q;
		pass   = 1'b0;

		if (pos_q == 17'd0) begin
			type_n = data_byte[7:6];
			tr_n   = data_byte[5];
			win_n  = data_byte[4:0];
			if (data_byte[7:6] == TYPE_NONE) begin
				err_n = ST_BAD_TYPE;
			end else if (data_byte[7:6] != TYPE_DATA && data_byte[5]) begin
				err_n = ST_BAD_TR;
			end
		end
		is_data = (type_n == TYPE_DATA);
		has_len = is_data && (len_q != 16'd0);
		hlen    = is_data ? HDR_DATA : HDR_SHORT;
		ts_idx  = pos_q[1:0] - (is_data ? 2'd0 : 2'd2);

		if (pos_q < hlen) begin
			crc_n = crc32_byte(crc_q,
				(pos_q == 17'd0) ? (data_byte & TR_CLEAR_MASK) : data_byte);
			if (is_data && (pos_q == 17'd1 || pos_q == 17'd2)) begin
				if (pos_q == 17'd1) begin
					len_n[15:8] = data_byte;
				end else begin
					len_n[7:0] = data_byte;
					if (err_n == ST_OK && {len_q[15:8], data_byte} > max_payload_len) begin
						err_n = ST_BAD_LEN;
					end
				end
			end else if (pos_q == hlen - 17'd5) begin
				seq_n = data_byte;
			end else if (pos_q >= hlen - 17'd4) begin
				ts_n[{ts_idx, 3'b000} +: 8] = data_byte;
			end
		end else if (pos_q < hlen + 17'd4) begin
			rcrc_n = rc_shift;
			if (pos_q == hlen + 17'd3) begin
				if (err_n == ST_OK) begin
					if (~crc_q != rc_shift) begin
						err_n = ST_CRC;
					end else if (len_q != 16'd0 && tr_n) begin
						err_n = ST_INCONS;
					end
				end
				crc_n  = CRC_INIT;
				rcrc_n = 32'd0;
			end
		end else if (has_len && pos_q < pay_end) begin
			crc_n = crc32_byte(crc_q, data_byte);
			pass  = (err_n == ST_OK);
		end else if (has_len && pos_q < crc_end) begin
			rcrc_n = rc_shift;
			if (pos_q == crc_end - 17'd1 && err_n == ST_OK && ~crc_q != rc_shift) begin
				err_n = ST_CRC;
			end
		end

		pos_n = (pos_q != POS_MAX) ? pos_q + 17'd1 : pos_q;

		if (pos_n < HDR_SHORT) begin
			status = ST_NO_HDR;
		end else if (err_n == ST_BAD_TYPE || err_n == ST_BAD_TR) begin
			status = err_n;
		end else if (is_data && pos_n < HDR_DATA) begin
			status = ST_NO_HDR;
		end else if (err_n != ST_OK) begin
			status = err_n;
		end else if (pos_n < hlen + 17'd4) begin
			status = ST_TRUNC;
		end else if (len_q == 16'd0) begin
			status = ST_OK;
		end else if (pos_n < crc_end) begin
			status = ST_TRUNC;
		end else begin
			status = ST_OK;
		end

		result = '0;
		if (fire && last_byte) begin
			result.valid       = 1'b1;
			result.item_kind   = KIND_REPORT;
			result.status      = status;
			result.type_code   = type_n;
			result.trunc_flag  = tr_n;
			result.window      = win_n;
			result.seq_number  = seq_n;
			result.payload_len = len_q;
			result.timestamp   = ts_n;
		end else if (fire && pass) begin
			result.valid        = 1'b1;
			result.item_kind    = KIND_PAYLOAD;
			result.payload_byte = data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
			rcrc_q <= '0;
			type_q <= '0;
			tr_q   <= 1'b0;
			win_q  <= '0;
			seq_q  <= '0;
			len_q  <= '0;
			ts_q   <= '0;
			err_q  <= ST_OK;
		end else if (fire) begin
			if (last_byte) begin
				pos_q  <= '0;
				crc_q  <= CRC_INIT;
				rcrc_q <= '0;
				type_q <= '0;
				tr_q   <= 1'b0;
				win_q  <= '0;
				seq_q  <= '0;
				len_q  <= '0;
				ts_q   <= '0;
				err_q  <= ST_OK;
			end else begin
				pos_q  <= pos_n;
				crc_q  <= crc_n;
				rcrc_q <= rcrc_n;
				type_q <= type_n;
				tr_q   <= tr_n;
				win_q  <= win_n;
				seq_q  <= seq_n;
				len_q  <= len_n;
				ts_q   <= ts_n;
				err_q  <= err_n;
			end
		end
	end

endmodule

[sv/packet_header_crc_checker.sv]
// An input transfer reaches its result transfer through the input register,
// then the result register.
// Throughput: one byte per cycle unless the output stalls; the bytewise CRC32
// update and field capture sit between the input register and the result register.
// Reset: arst_n clears all parser state and sets max_payload_len to 512.
`include "assert_macros.svh"

module packet_header_crc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // payload_byte, status, type_code, trunc_flag,
	                               // window, seq_number, payload_len, timestamp, zero pad
	output logic        m_tuser,   // item_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // max_payload_len
);
	import phcc_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic [15:0]  max_len_q;
	logic         advance;
	logic         fire;
	phcc_result_t res;
	phcc_result_t out_q;

	assign cfg_ready = 1'b1;
	assign advance   = !m_tvalid || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 16'd512;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	phcc_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.data_byte       (byte_s1),
		.last_byte       (last_s1),
		.max_payload_len (max_len_q),
		.result          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign m_tuser = out_q.item_kind;
	assign m_tdata = {5'd0, out_q.timestamp, out_q.payload_len, out_q.seq_number,
		out_q.window, out_q.trunc_flag, out_q.type_code, out_q.status,
		out_q.payload_byte};

	`ASSERT_IMPLIES(a_payload_clean, clk, arst_n, m_tvalid && m_tuser == KIND_PAYLOAD, m_tdata[79:8] == 72'd0)
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(last_s1))
	`ASSERT_IMPLIES(a_ok_has_type, clk, arst_n, m_tvalid && m_tuser == KIND_REPORT && m_tdata[10:8] == ST_OK, m_tdata[12:11] != TYPE_NONE)

endmodule
